### src/iwo_pkg.sv
// shared types, coefficient tables and coefficient functions for the imdct window overlap unit
`timescale 1ns / 1ps

package iwo_pkg;

    localparam int LINES     = 18;
    localparam int COEF_BITS = 23;
    localparam int COEF_W    = 25;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_WMUL,
        ST_WACC,
        ST_FETCH,
        ST_EMIT,
        ST_SAVE
    } t_state;

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_START  = 2'd1,
        KIND_SHORT  = 2'd2,
        KIND_STOP   = 2'd3
    } t_kind;

    // round(2^23 * cos(pi*j/72)), j = 0..36
    localparam logic [23:0] QCOS [37] = '{
        24'd8388608, 24'd8380624, 24'd8356687, 24'd8316842, 24'd8261166, 24'd8189764,
        24'd8102773, 24'd8000358, 24'd7882713, 24'd7750063, 24'd7602661, 24'd7440786,
        24'd7264748, 24'd7074880, 24'd6871545, 24'd6655130, 24'd6426047, 24'd6184731,
        24'd5931642, 24'd5667261, 24'd5392093, 24'd5106661, 24'd4811508, 24'd4507196,
        24'd4194304, 24'd3873428, 24'd3545179, 24'd3210181, 24'd2869073, 24'd2522503,
        24'd2171132, 24'd1815627, 24'd1456666, 24'd1094933, 24'd731115,  24'd365906,
        24'd0
    };

    localparam logic signed [COEF_W-1:0] COEF_ONE = 25'sd8388608;

    // cos(pi*r/72) in Q.23, r in 0..143
    function automatic logic signed [COEF_W-1:0] cos_q(input logic [7:0] r);
        logic [7:0] j;
        logic       neg;
        logic signed [COEF_W-1:0] mag;
        begin
            if (r <= 8'd36) begin
                j = r;
                neg = 1'b0;
            end else if (r <= 8'd72) begin
                j = 8'd72 - r;
                neg = 1'b1;
            end else if (r <= 8'd108) begin
                j = r - 8'd72;
                neg = 1'b1;
            end else begin
                j = 8'd144 - r;
                neg = 1'b0;
            end
            mag = $signed({1'b0, QCOS[j[5:0]]});
            cos_q = neg ? -mag : mag;
        end
    endfunction

    // sin(pi*a/72), a in 0..72
    function automatic logic signed [COEF_W-1:0] sin_q(input logic [6:0] a);
        logic [7:0] t;
        begin
            t = 8'd180 - {1'b0, a};
            if (t >= 8'd144) begin
                t = t - 8'd144;
            end
            sin_q = cos_q(t);
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] window_coef(input t_kind kind,
                                                             input logic [5:0] i);
        logic [6:0] odd_arg;
        logic [6:0] mid_arg;
        begin
            odd_arg = {i, 1'b1};
            mid_arg = 7'd0;
            window_coef = sin_q(odd_arg);
            if (kind == KIND_START) begin
                mid_arg = 7'(6 * (i - 6'd18)) + 7'd3;
                if (i >= 6'd30) begin
                    window_coef = '0;
                end else if (i >= 6'd24) begin
                    window_coef = sin_q(mid_arg);
                end else if (i >= 6'd18) begin
                    window_coef = COEF_ONE;
                end
            end else if (kind == KIND_STOP) begin
                mid_arg = 7'(6 * (i - 6'd6)) + 7'd3;
                if (i < 6'd6) begin
                    window_coef = '0;
                end else if (i < 6'd12) begin
                    window_coef = sin_q(mid_arg);
                end else if (i < 6'd18) begin
                    window_coef = COEF_ONE;
                end
            end
        end
    endfunction

endpackage

### src/imdct_window_overlap_unit.sv
// imdct window overlap unit: 36/12-point imdct, sine window and overlap-add per subband
//
// input channel (s_axis): one transaction per frequency line. the line with
// line_index 17 starts the transform of the 18 lines collected so far for the
// channel and subband it carries; line_index 18..31 is dropped.
// output channel (m_axis): 18 transactions per run, positions 0..17, tlast on 17.
// one multiply-accumulate unit does all the work: each long output position
// takes line-buffer reads, one per line, a pipeline drain, rounding, window
// multiply and an overlap-store access: a read and output in the first half,
// a write in the second. s_axis_tready is low while a run is in progress, so
// no line is accepted until the run has ended.
// the overlap store is a single-port memory with a valid bit per channel and
// subband row; reset clears the valid bits, so rows read as zero until their
// first run, and the unit is ready in the first cycle after reset.
// a stalled receiver holds the current output in the output register and the
// sequencer waits at the next output position; no transaction is lost.
`timescale 1ns / 1ps

module imdct_window_overlap_unit
    import iwo_pkg::*;
#(
    parameter int NUM_SUBBANDS = 32,
    parameter int NUM_CHANNELS = 2,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // line_value, chan_index, subband_index, line_index, zero fill
    input  logic [((SAMPLE_WIDTH+11+7)/8)*8-1:0] s_axis_tdata,
    // block_kind
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // time_value, out_position, zero fill
    output logic [((SAMPLE_WIDTH+5+7)/8)*8-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int OUT_W     = ((SW + 5 + 7) / 8) * 8;
    localparam int ROWS      = NUM_CHANNELS * NUM_SUBBANDS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH     = ROWS * LINES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PROD_W    = SW + COEF_W;
    localparam int ACC_W     = PROD_W + 5;
    localparam int X_W       = SW + 5;
    localparam int WPROD_W   = X_W + COEF_W;
    localparam int BLK_W     = SW + 6;

    localparam logic signed [BLK_W:0] SMAX = {{(BLK_W-SW+2){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [BLK_W:0] SMIN = {{(BLK_W-SW+2){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] VMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = {1'b1, {(SW-1){1'b0}}};

    t_state r_state, n_state;

    // input fields
    logic [SW-1:0] in_line;
    logic          in_chan;
    logic [4:0]    in_sb;
    logic [4:0]    in_idx;
    logic          in_fire;
    logic          trigger;

    assign in_line = s_axis_tdata[SW-1:0];
    assign in_chan = s_axis_tdata[SW];
    assign in_sb   = s_axis_tdata[SW+5:SW+1];
    assign in_idx  = s_axis_tdata[SW+10:SW+6];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign trigger = in_fire && (in_idx == 5'(LINES - 1));

    // run context
    t_kind             r_kind;
    logic              r_sb_odd;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_base;
    logic [ROW_W-1:0]  row_in;
    logic [4:0]        sb_red;
    logic              ch_red;

    always_comb begin
        sb_red = '0;
        for (int j = 0; j < 32; j++) begin
            if (in_sb == 5'(j)) begin
                sb_red = 5'(j % NUM_SUBBANDS);
            end
        end
        ch_red = (NUM_CHANNELS == 1) ? 1'b0 : in_chan;
        row_in = ROW_W'(32'(ch_red) * 32'(NUM_SUBBANDS) + 32'(sb_red));
    end

    // sequencer position
    logic [5:0]  r_p;
    logic        r_term;
    logic [4:0]  r_k;
    logic [4:0]  r_nk;
    logic [4:0]  r_lbase;
    logic [7:0]  r_m;
    logic [7:0]  r_step;
    logic signed [COEF_W-1:0] r_win;

    // term selection for the current output position
    logic        term_ok;
    logic [5:0]  t_i;
    logic [4:0]  t_lbase;
    logic [4:0]  t_nk;
    logic [7:0]  t_m0;
    logic [8:0]  t_step_raw;
    logic [7:0]  t_step;
    logic signed [COEF_W-1:0] t_win;
    logic [5:0]  pm;
    logic [1:0]  q;
    logic [2:0]  rr;
    logic        in_short;

    always_comb begin
        pm = r_p - 6'd6;
        in_short = (r_p >= 6'd6) && (r_p < 6'd30);
        if (pm >= 6'd18) begin
            q = 2'd3;
        end else if (pm >= 6'd12) begin
            q = 2'd2;
        end else if (pm >= 6'd6) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        rr = 3'(pm - 6'(6 * q));
        term_ok = 1'b0;
        t_i = '0;
        t_lbase = '0;
        t_nk = 5'd5;
        t_m0 = '0;
        t_step_raw = '0;
        t_win = '0;
        if (r_kind != KIND_SHORT) begin
            term_ok = !r_term;
            t_i = r_p;
            t_nk = 5'(LINES - 1);
            t_m0 = 8'(2 * r_p) + 8'd19;
            t_step_raw = 9'(4 * r_p) + 9'd38;
            t_win = window_coef(r_kind, r_p);
        end else begin
            if (!r_term) begin
                term_ok = in_short && (q <= 2'd2);
                t_i = 6'(rr);
                t_lbase = 5'(6 * q);
            end else begin
                term_ok = in_short && (q >= 2'd1);
                t_i = 6'(rr) + 6'd6;
                t_lbase = 5'(6 * (q - 2'd1));
            end
            t_m0 = 8'(6 * t_i) + 8'd21;
            t_step_raw = 9'(12 * t_i) + 9'd42;
            t_win = sin_q(7'(6 * t_i) + 7'd3);
        end
        t_step = (t_step_raw >= 9'd144) ? 8'(t_step_raw - 9'd144) : t_step_raw[7:0];
    end

    // line buffer memory
    logic [SW-1:0] r_lb_mem [LINES];
    logic [SW-1:0] r_lb_rdata;
    logic [4:0]    lb_raddr;

    assign lb_raddr = r_lbase + r_k;

    always_ff @(posedge i_clk) begin
        if (in_fire && (in_idx < 5'(LINES))) begin
            r_lb_mem[in_idx] <= in_line;
        end
        if (r_state == ST_MAC) begin
            r_lb_rdata <= r_lb_mem[lb_raddr];
        end
    end

    // overlap store memory
    logic [SW-1:0]     r_ovl_mem [DEPTH];
    logic [SW-1:0]     r_ovl_rdata;
    logic [ROWS-1:0]   r_row_valid;
    logic              ovl_we;
    logic              ovl_re;
    logic [ADDR_W-1:0] ovl_addr;
    logic [SW-1:0]     ovl_wdata;

    always_ff @(posedge i_clk) begin
        if (ovl_we) begin
            r_ovl_mem[ovl_addr] <= ovl_wdata;
        end
        if (ovl_re) begin
            r_ovl_rdata <= r_ovl_mem[ovl_addr];
        end
    end

    // multiply-accumulate datapath
    logic                     r_v1, r_v2;
    logic signed [COEF_W-1:0] r_coef;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [X_W-1:0]    r_x;
    logic signed [WPROD_W-1:0] r_wprod;
    logic signed [BLK_W-1:0]  r_blk;
    logic [8:0]               m_sum;
    logic signed [ACC_W:0]    acc_rnd;
    logic signed [WPROD_W:0]  wprod_rnd;

    assign m_sum = {1'b0, r_m} + {1'b0, r_step};
    assign acc_rnd = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(1 << (COEF_BITS - 1));
    assign wprod_rnd = {r_wprod[WPROD_W-1], r_wprod} + (WPROD_W+1)'(1 << (COEF_BITS - 1));

    // output value path
    logic signed [BLK_W:0] ovl_sum;
    logic signed [SW-1:0]  sum_sat;
    logic signed [SW-1:0]  emit_val;
    logic signed [BLK_W:0] blk_ext;
    logic signed [SW-1:0]  save_val;
    logic                  out_free;
    logic [SW-1:0]         store_val;

    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign store_val = r_row_valid[r_row] ? r_ovl_rdata : '0;

    always_comb begin
        ovl_sum = {r_blk[BLK_W-1], r_blk} + (BLK_W+1)'($signed(store_val));
        if (ovl_sum > SMAX) begin
            sum_sat = VMAX;
        end else if (ovl_sum < SMIN) begin
            sum_sat = VMIN;
        end else begin
            sum_sat = ovl_sum[SW-1:0];
        end
        emit_val = sum_sat;
        if (r_sb_odd && r_p[0]) begin
            emit_val = (sum_sat == VMIN) ? VMAX : -sum_sat;
        end
        blk_ext = {r_blk[BLK_W-1], r_blk};
        if (blk_ext > SMAX) begin
            save_val = VMAX;
        end else if (blk_ext < SMIN) begin
            save_val = VMIN;
        end else begin
            save_val = r_blk[SW-1:0];
        end
    end

    always_comb begin
        ovl_re = (r_state == ST_FETCH);
        ovl_we = (r_state == ST_SAVE);
        if (r_state == ST_SAVE) begin
            ovl_addr = r_base + ADDR_W'(r_p - 6'd18);
        end else begin
            ovl_addr = r_base + ADDR_W'(r_p);
        end
        ovl_wdata = save_val;
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (trigger) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (term_ok) begin
                    n_state = ST_MAC;
                end else if (r_term) begin
                    n_state = (r_p < 6'(LINES)) ? ST_FETCH : ST_SAVE;
                end
            end
            ST_MAC: begin
                if (r_k == r_nk) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_WMUL;
            ST_WMUL:  n_state = ST_WACC;
            ST_WACC: begin
                if (r_term) begin
                    n_state = (r_p < 6'(LINES)) ? ST_FETCH : ST_SAVE;
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_FETCH: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SAVE: begin
                n_state = (r_p == 6'd35) ? ST_IDLE : ST_SETUP;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_row_valid <= '0;
            r_p <= '0;
            r_term <= 1'b0;
            r_k <= '0;
        end else begin
            r_v1 <= (r_state == ST_MAC);
            r_v2 <= r_v1;
            if (trigger) begin
                r_p <= '0;
                r_term <= 1'b0;
            end
            if ((r_state == ST_SETUP) && !term_ok && !r_term) begin
                r_term <= 1'b1;
            end
            if ((r_state == ST_WACC) && !r_term) begin
                r_term <= 1'b1;
            end
            if ((r_state == ST_SETUP) && term_ok) begin
                r_k <= '0;
            end else if (r_state == ST_MAC) begin
                r_k <= r_k + 5'd1;
            end
            if (((r_state == ST_EMIT) && out_free) || (r_state == ST_SAVE)) begin
                r_p <= r_p + 6'd1;
                r_term <= 1'b0;
            end
            if ((r_state == ST_SAVE) && (r_p == 6'd35)) begin
                r_row_valid[r_row] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (trigger) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_sb_odd <= sb_red[0];
            r_row <= row_in;
            r_base <= ADDR_W'(32'(row_in) * 32'(LINES));
            r_blk <= '0;
        end
        if ((r_state == ST_SETUP) && term_ok) begin
            r_m <= t_m0;
            r_step <= t_step;
            r_lbase <= t_lbase;
            r_nk <= t_nk;
            r_win <= t_win;
            r_acc <= '0;
        end
        if (r_state == ST_MAC) begin
            r_coef <= cos_q(r_m);
            r_m <= (m_sum >= 9'd144) ? 8'(m_sum - 9'd144) : m_sum[7:0];
        end
        if (r_v1) begin
            r_prod <= PROD_W'($signed(r_lb_rdata) * r_coef);
        end
        if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == ST_ROUND) begin
            r_x <= X_W'(acc_rnd >>> COEF_BITS);
        end
        if (r_state == ST_WMUL) begin
            r_wprod <= WPROD_W'(r_x * r_win);
        end
        if (r_state == ST_WACC) begin
            r_blk <= r_blk + BLK_W'(wprod_rnd >>> COEF_BITS);
        end
        if (((r_state == ST_EMIT) && out_free) || (r_state == ST_SAVE)) begin
            r_blk <= '0;
        end
    end

    // output register
    logic          r_out_valid;
    logic [SW-1:0] r_out_val;
    logic [4:0]    r_out_pos;
    logic          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_out_val <= emit_val;
            r_out_pos <= r_p[4:0];
            r_out_last <= (r_p == 6'(LINES - 1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast = r_out_last;
    assign m_axis_tdata = OUT_W'({r_out_pos, r_out_val});

`ifndef NO_ASSERTIONS
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[SW+4:SW] == 5'(LINES - 1))
        else $error("tlast on a position other than the last");

    a_save_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ovl_we |-> (r_p >= 6'(LINES)) && (r_p <= 6'd35))
        else $error("overlap store written outside the second half");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_fire)
        else $error("line accepted during a run");

    a_emit_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_p < 6'(LINES)))
        else $error("emit outside the first half");
`endif

endmodule
